// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

// File: src/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and constants shared by the heap queue controller and datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int KEY_W    = 32;
  localparam int CNT_O_W  = 7;
  localparam int STAT_W   = 2;
  localparam int IN_TD_W  = 32;
  localparam int OUT_TD_W = 72;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_REM_ROOT,
    ST_REM_LAST,
    ST_DN_CHK,
    ST_DN_L,
    ST_DN_CMP,
    ST_TOP_RD,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_PARENT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_KEY,
    WR_RDATA,
    WR_CHOSEN
  } wr_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    start_ins;
    logic    set_full;
    logic    set_empty;
    logic    cap_removed;
    logic    cap_last;
    logic    cap_left;
    logic    move_up;
    logic    move_down;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic op_remove;
    logic full;
    logic empty;
    logic at_root;
    logic parent_less;
    logic left_out;
    logic child_gt;
  } stat_t;

endpackage

// File: src/mhpq_dp.sv
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap store, sift position, moving key, fill count and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mhpq_dp #(
  parameter int CAPACITY = 127
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mhpq_pkg::cmd_t                         cmd,
  output mhpq_pkg::stat_t                        stat,
  input  logic                                   in_op,
  input  logic signed [mhpq_pkg::KEY_W-1:0]      in_value,
  output logic signed [mhpq_pkg::KEY_W-1:0]      res_removed,
  output logic signed [mhpq_pkg::KEY_W-1:0]      res_top,
  output logic        [mhpq_pkg::CNT_O_W-1:0]    res_count,
  output logic        [mhpq_pkg::STAT_W-1:0]     res_status
);
  import mhpq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = IDX_W + 1;
  localparam int DEPTH = 2 ** IDX_W;

  logic signed [KEY_W-1:0] mem [DEPTH];

  logic signed [KEY_W-1:0] rd_data_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] left_r;
  logic signed [KEY_W-1:0] removed_r;
  logic                    op_r;
  status_t                 status_r;
  logic [IDX_W-1:0]        pos_r;
  logic [IDX_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        cnt_nxt;

  logic [EXT_W-1:0]        left_idx;
  logic [EXT_W-1:0]        right_idx;
  logic                    has_right;
  logic                    right_pick;
  logic signed [KEY_W-1:0] chosen_val;
  logic [IDX_W-1:0]        chosen_idx;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [KEY_W-1:0] wr_data;

  assign left_idx   = {pos_r, 1'b0};
  assign right_idx  = {pos_r, 1'b1};
  assign has_right  = right_idx <= {1'b0, cnt_r};
  assign right_pick = has_right && (left_r < rd_data_r);
  assign chosen_val = right_pick ? rd_data_r : left_r;
  assign chosen_idx = right_pick ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ROOT:   rd_addr = IDX_W'(1);
      RD_PARENT: rd_addr = pos_r >> 1;
      RD_LAST:   rd_addr = cnt_r;
      RD_LEFT:   rd_addr = left_idx[IDX_W-1:0];
      RD_RIGHT:  rd_addr = right_idx[IDX_W-1:0];
      default:   rd_addr = IDX_W'(1);
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_KEY:    wr_data = key_r;
      WR_RDATA:  wr_data = rd_data_r;
      WR_CHOSEN: wr_data = chosen_val;
      default:   wr_data = key_r;
    endcase
  end

  // heap store: one write at the sift position, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[pos_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.start_ins) begin
      cnt_nxt = cnt_r + IDX_W'(1);
    end else if (cmd.cap_last) begin
      cnt_nxt = cnt_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r      <= in_op;
      key_r     <= in_value;
      removed_r <= '0;
      status_r  <= STAT_OK;
    end
    if (cmd.set_full) begin
      status_r <= STAT_FULL;
    end
    if (cmd.set_empty) begin
      status_r <= STAT_EMPTY;
    end
    if (cmd.start_ins) begin
      pos_r <= cnt_r + IDX_W'(1);
    end
    if (cmd.cap_removed) begin
      removed_r <= rd_data_r;
    end
    if (cmd.cap_last) begin
      key_r <= rd_data_r;
      pos_r <= IDX_W'(1);
    end
    if (cmd.cap_left) begin
      left_r <= rd_data_r;
    end
    if (cmd.move_up) begin
      pos_r <= pos_r >> 1;
    end
    if (cmd.move_down) begin
      pos_r <= chosen_idx;
    end
    if (cmd.out_load) begin
      res_removed <= removed_r;
      res_top     <= (cnt_r == '0) ? '0 : rd_data_r;
      res_count   <= CNT_O_W'(cnt_r);
      res_status  <= status_r;
    end
  end

  assign stat.op_remove   = op_r;
  assign stat.full        = cnt_r == IDX_W'(CAPACITY);
  assign stat.empty       = cnt_r == '0;
  assign stat.at_root     = pos_r == IDX_W'(1);
  assign stat.parent_less = rd_data_r < key_r;
  assign stat.left_out    = left_idx > {1'b0, cnt_r};
  assign stat.child_gt    = key_r < chosen_val;

  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= IDX_W'(CAPACITY), "fill count above capacity")
  `ASSERT_IMPL(a_wr_nonzero, cmd.wr_en, pos_r != '0, "heap write at index zero")
  `ASSERT_IMPL(a_wr_in_heap, cmd.wr_en, pos_r <= cnt_r || cnt_r == '0, "heap write past last entry")

endmodule

// File: src/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for insert sift-up and remove sift-down, plus the result valid register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mhpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  mhpq_pkg::stat_t   stat,
  output mhpq_pkg::cmd_t    cmd
);
  import mhpq_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    cmd.rd_sel = RD_ROOT;
    cmd.wr_sel = WR_KEY;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!stat.op_remove) begin
          if (stat.full) begin
            cmd.set_full = 1'b1;
            state_nxt    = ST_TOP_RD;
          end else begin
            cmd.start_ins = 1'b1;
            state_nxt     = ST_UP_CHK;
          end
        end else begin
          if (stat.empty) begin
            cmd.set_empty = 1'b1;
            state_nxt     = ST_TOP_RD;
          end else begin
            state_nxt = ST_REM_ROOT;
          end
        end
      end
      ST_UP_CHK: begin
        if (stat.at_root) begin
          cmd.wr_en = 1'b1;
          state_nxt = ST_TOP_RD;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_nxt  = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.parent_less) begin
          // move parent down into the hole, climb one level
          cmd.wr_sel  = WR_RDATA;
          cmd.move_up = 1'b1;
          state_nxt   = ST_UP_CHK;
        end else begin
          state_nxt = ST_TOP_RD;
        end
      end
      ST_REM_ROOT: begin
        cmd.cap_removed = 1'b1;
        cmd.rd_sel      = RD_LAST;
        state_nxt       = ST_REM_LAST;
      end
      ST_REM_LAST: begin
        cmd.cap_last = 1'b1;
        state_nxt    = ST_DN_CHK;
      end
      ST_DN_CHK: begin
        if (stat.left_out) begin
          cmd.wr_en = 1'b1;
          state_nxt = ST_TOP_RD;
        end else begin
          cmd.rd_sel = RD_LEFT;
          state_nxt  = ST_DN_L;
        end
      end
      ST_DN_L: begin
        cmd.cap_left = 1'b1;
        cmd.rd_sel   = RD_RIGHT;
        state_nxt    = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.child_gt) begin
          // lift the larger child into the hole, descend one level
          cmd.wr_sel    = WR_CHOSEN;
          cmd.move_down = 1'b1;
          state_nxt     = ST_DN_CHK;
        end else begin
          state_nxt = ST_TOP_RD;
        end
      end
      ST_TOP_RD: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  `ASSERT_NEXT(a_accept_decode, in_tvalid && in_tready, state_r == ST_DECODE,
               "accepted request did not start decode")
  `ASSERT_IMPL(a_load_free, cmd.out_load, !out_valid_r || out_tready,
               "result overwritten before it was taken")
  `ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_r && state_r == ST_IDLE,
               "loaded result not presented")

endmodule

// File: src/max_heap_priority_queue_unit.sv
// One request at a time: the next is accepted once the controller returns to idle after
//   the result loads; the load itself waits until the result register is free.
// Reset: rst_n synchronous active low empties the queue; the store is not cleared.
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap priority queue of signed 32-bit keys with insert and
// remove-max requests; each request returns one result.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit #(
  parameter int CAPACITY = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [0:0]  in_tuser,   // [0] operation (0 insert, 1 remove max)
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] removed_value, [63:32] top_value,
                                  // [70:64] entry_count, [71] zero pad
  output logic [1:0]  out_tuser   // [1:0] status
);
  import mhpq_pkg::*;

  cmd_t                    cmd;
  stat_t                   stat;
  logic signed [KEY_W-1:0] res_removed;
  logic signed [KEY_W-1:0] res_top;
  logic [CNT_O_W-1:0]      res_count;
  logic [STAT_W-1:0]       res_status;

  // Controller: walks the sift loop one tree level per pass. Insert climbs
  // with a parent read and compare each level; remove descends with a
  // left read, a right read and a compare each level. A final root read
  // fetches the new maximum before the result is loaded.
  mhpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: the heap store is kept in hole form -- the moving key stays in
  // a register, and each step copies the displaced parent or child into the
  // hole, so one write per level replaces a swap.
  mhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_tuser[0]),
    .in_value    (in_tdata[KEY_W-1:0]),
    .res_removed (res_removed),
    .res_top     (res_top),
    .res_count   (res_count),
    .res_status  (res_status)
  );

  // Pack the result; the output register lives in the datapath so a new
  // request is taken while a finished result still waits on out_tready.
  assign out_tdata = {1'b0, res_count, res_top, res_removed};
  assign out_tuser = res_status;

endmodule

// File: verif/max_heap_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit_tb
// Self-checking bench for the max-heap priority queue. A behavioral heap
// predicts every result at request accept time, and a result monitor compares
// each returned result with the oldest prediction, field by field. Directed
// tests cover the empty and full refusals, key extremes and equal keys;
// random mixes sweep the fill level under varying request and result idling.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit_tb;
  import mhpq_pkg::*;

  localparam int HEAP_DEPTH = 127;

  // The run limit covers about 580 requests, each at worst a remove sinking six levels,
  // plus request gaps and result stalls, several times over.
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [31:0] removed;
    logic signed [31:0] top;
    logic [6:0]         count;
    status_t            status;
  } heap_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  // Behavioral heap: one-based key store and its fill level.
  logic signed [31:0] model_keys [1:HEAP_DEPTH];
  int                 model_fill = 0;

  heap_result_t pending_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int n_inserts      = 0;
  int n_removes      = 0;
  int n_full_refused = 0;
  int n_empty_refused = 0;
  int n_checked      = 0;
  int deepest_fill   = 0;

  max_heap_priority_queue_unit #(
    .CAPACITY(HEAP_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the behavioral heap and return the result it yields.
  function automatic heap_result_t heap_apply(input op_t op, input logic signed [31:0] key);
    heap_result_t       res;
    int                 idx;
    int                 par;
    int                 lc;
    int                 big;
    logic signed [31:0] tmp;
    res.removed = '0;
    res.status  = STAT_OK;
    if (op == OP_INSERT) begin
      if (model_fill >= HEAP_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        model_fill++;
        model_keys[model_fill] = key;
        idx = model_fill;
        // Sift up: climb only past a strictly smaller parent.
        while (idx > 1) begin
          par = idx / 2;
          if (!(model_keys[par] < model_keys[idx])) break;
          tmp = model_keys[par];
          model_keys[par] = model_keys[idx];
          model_keys[idx] = tmp;
          idx = par;
        end
      end
    end else begin
      if (model_fill == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.removed = model_keys[1];
        model_keys[1] = model_keys[model_fill];
        model_fill--;
        idx = 1;
        // Sift down: left child wins a tie, swap only with a strictly larger child.
        while (1) begin
          lc = 2 * idx;
          if (lc > model_fill) break;
          big = lc;
          if (lc + 1 <= model_fill && model_keys[lc] < model_keys[lc + 1]) big = lc + 1;
          if (!(model_keys[idx] < model_keys[big])) break;
          tmp = model_keys[idx];
          model_keys[idx] = model_keys[big];
          model_keys[big] = tmp;
          idx = big;
        end
      end
    end
    res.top   = (model_fill != 0) ? model_keys[1] : 32'sd0;
    res.count = 7'(model_fill);
    return res;
  endfunction

  // Present one request, idling first at the current rate. Predict on accept
  // and hold tvalid high so a back-to-back request needs no extra edge.
  task automatic send_request(input op_t op, input logic [31:0] key);
    heap_result_t exp_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tuser  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    exp_res = heap_apply(op, key);
    pending_results.push_back(exp_res);
    if (op == OP_INSERT) n_inserts++;
    else n_removes++;
    if (exp_res.status == STAT_FULL) n_full_refused++;
    if (exp_res.status == STAT_EMPTY) n_empty_refused++;
    if (model_fill > deepest_fill) deepest_fill = model_fill;
  endtask

  task automatic set_pace(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Remove on an empty queue straight out of reset.
  task automatic test_empty_remove();
    send_request(OP_REMOVE, $urandom);
  endtask

  // Extreme keys, alternating bit patterns and equal keys, then drain past empty.
  task automatic test_key_extremes();
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0001);
    send_request(OP_INSERT, 32'h0000_0005);
    send_request(OP_INSERT, 32'h0000_0005);
    send_request(OP_INSERT, 32'h0000_0005);
    send_request(OP_INSERT, 32'hAAAA_AAAA);
    send_request(OP_INSERT, 32'h5555_5555);
    repeat (11) send_request(OP_REMOVE, $urandom);
  endtask

  // Fill to capacity, push against the full queue, then drain past empty.
  task automatic test_full_heap();
    while (model_fill < HEAP_DEPTH) send_request(OP_INSERT, $urandom);
    send_request(OP_INSERT, 32'h7FFF_FFFF);
    send_request(OP_INSERT, $urandom);
    while (model_fill > 0) send_request(OP_REMOVE, $urandom);
    send_request(OP_REMOVE, $urandom);
  endtask

  // Random requests in runs of twenty, each run with its own insert bias so the
  // fill level wanders up and down. Keys mix full-range, small clustered values
  // (many duplicates) and the extremes.
  task automatic test_random_mix(input int n_items);
    int          insert_pct;
    logic [31:0] key;
    for (int i = 0; i < n_items; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(3))
          0: insert_pct = 25;
          1: insert_pct = 50;
          2: insert_pct = 75;
          default: insert_pct = 90;
        endcase
      end
      case ($urandom_range(3))
        0, 1: key = $urandom;
        2: key = 32'($urandom_range(15)) - 32'd8;
        default: begin
          case ($urandom_range(3))
            0: key = 32'h8000_0000;
            1: key = 32'h7FFF_FFFF;
            2: key = 32'h0000_0000;
            default: key = 32'hFFFF_FFFF;
          endcase
        end
      endcase
      if ($urandom_range(99) < insert_pct) send_request(OP_INSERT, key);
      else send_request(OP_REMOVE, key);
    end
  endtask

  // Result monitor: randomize tready every cycle and check each accepted result
  // against the oldest prediction.
  always @(posedge clk) begin : result_check
    heap_result_t exp_res;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %h", out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (out_tdata[31:0] !== exp_res.removed) begin
          $error("removed_value: expected %0d, got %0d", exp_res.removed,
                 $signed(out_tdata[31:0]));
          error_count++;
        end
        if (out_tdata[63:32] !== exp_res.top) begin
          $error("top_value: expected %0d, got %0d", exp_res.top, $signed(out_tdata[63:32]));
          error_count++;
        end
        if (out_tdata[70:64] !== exp_res.count) begin
          $error("entry_count: expected %0d, got %0d", exp_res.count, out_tdata[70:64]);
          error_count++;
        end
        if (out_tdata[71] !== 1'b0) begin
          $error("tdata pad: expected 0, got %b", out_tdata[71]);
          error_count++;
        end
        if (out_tuser !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin : run_tests
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_pace(10, 45);
    test_empty_remove();
    test_key_extremes();
    test_full_heap();
    test_random_mix(100);

    set_pace(45, 10);
    test_random_mix(100);

    set_pace(0, 0);
    test_random_mix(100);

    in_tvalid <= 1'b0;

    // Drain outstanding results, then allow the block to settle.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end

    $display("Run covered %0d inserts and %0d removes, %0d full and %0d empty refusals.",
             n_inserts, n_removes, n_full_refused, n_empty_refused);
    $display("Checked %0d results; deepest fill level %0d.", n_checked, deepest_fill);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
